/* rtl/vsbp_pkg.sv */
`timescale 1ns / 1ps

package vsbp_pkg;

    // field widths
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned GROUP_W  = 6;
    localparam int unsigned DATA_W   = 5;
    localparam int unsigned BITS_W   = 7;
    localparam int unsigned CNT_W    = 3;
    localparam int unsigned ACC_W    = 12;

    // action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_FIXED  = 2'd0,
        ACT_EXT    = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

endpackage

/* rtl/vsbp_in_if.sv */
`timescale 1ns / 1ps

interface vsbp_in_if;
    logic                               valid;
    logic                               ready;
    logic [vsbp_pkg::ACTION_W-1:0]      action;
    logic [vsbp_pkg::VALUE_W-1:0]       value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

/* rtl/vsbp_out_if.sv */
`timescale 1ns / 1ps

interface vsbp_out_if;
    logic                               valid;
    logic                               ready;
    logic [vsbp_pkg::BYTE_W-1:0]        out_byte;
    logic                               last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

/* rtl/varint_six_bit_packer.sv */
`timescale 1ns / 1ps

// channel  | dir | payload               | handshake
// ---------+-----+-----------------------+------------------------------
// i_in     | in  | action[1:0], value[31:0] | valid & ready at rising edge
// o_out    | out | out_byte[7:0], last    | valid & ready at rising edge
//
// one group goes through the shared shift/merge unit per cycle while o_out does not stall:
// a fixed write is one group, an extended write 1 to 7 groups, a finish none.
// i_in.ready is high only while the sequencer is idle.
// a produced byte waits in a hold register until it is known whether another
// byte follows, so last can be set; o_out stalls hold the sequencer.
// i_rst_n is synchronous, active low, and clears the held bits.
module varint_six_bit_packer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    vsbp_in_if.sink         i_in,
    vsbp_out_if.source      o_out
);

    vsbp_pkg::t_state                   r_state, n_state;
    logic [vsbp_pkg::VALUE_W-1:0]       r_val, n_val;
    logic                               r_ext, n_ext;
    logic [vsbp_pkg::BITS_W-1:0]        r_bits, n_bits;
    logic [vsbp_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic [vsbp_pkg::BYTE_W-1:0]        r_hold, n_hold;
    logic                               r_hold_v, n_hold_v;
    logic [vsbp_pkg::BYTE_W-1:0]        r_ob, n_ob;
    logic                               r_olast, n_olast;
    logic                               r_ov, n_ov;

    // shared group unit signals
    logic                               more;
    logic [vsbp_pkg::GROUP_W-1:0]       grp;
    logic [vsbp_pkg::ACC_W-1:0]         acc;
    logic [vsbp_pkg::CNT_W:0]           sum;
    logic                               full;
    logic                               out_free;

    assign i_in.ready     = (r_state == vsbp_pkg::ST_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.last     = r_olast;

    // group select and merge into held bits
    always_comb begin
        more = r_ext && (r_val[vsbp_pkg::VALUE_W-1:vsbp_pkg::DATA_W] != '0);
        grp  = r_ext ? {more, r_val[vsbp_pkg::DATA_W-1:0]}
                     : r_val[vsbp_pkg::GROUP_W-1:0];
        acc  = {{(vsbp_pkg::ACC_W-vsbp_pkg::BITS_W){1'b0}}, r_bits}
             | ({{(vsbp_pkg::ACC_W-vsbp_pkg::GROUP_W){1'b0}}, grp} << r_cnt);
        sum  = {1'b0, r_cnt} + 4'd6;
        full = sum[vsbp_pkg::CNT_W];
    end

    assign out_free = !r_ov || o_out.ready;

    // sequencer next state and datapath
    always_comb begin
        n_state  = r_state;
        n_val    = r_val;
        n_ext    = r_ext;
        n_bits   = r_bits;
        n_cnt    = r_cnt;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        n_ob     = r_ob;
        n_olast  = r_olast;
        n_ov     = r_ov;

        // output register drains
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            vsbp_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    unique case (vsbp_pkg::t_action'(i_in.action))
                        vsbp_pkg::ACT_FIXED: begin
                            n_val   = {{(vsbp_pkg::VALUE_W-vsbp_pkg::GROUP_W){1'b0}},
                                       i_in.value[vsbp_pkg::GROUP_W-1:0]};
                            n_ext   = 1'b0;
                            n_state = vsbp_pkg::ST_RUN;
                        end
                        vsbp_pkg::ACT_EXT: begin
                            n_val   = i_in.value;
                            n_ext   = 1'b1;
                            n_state = vsbp_pkg::ST_RUN;
                        end
                        vsbp_pkg::ACT_FINISH: begin
                            n_hold   = {1'b0, r_bits};
                            n_hold_v = (r_cnt != '0);
                            n_bits   = '0;
                            n_cnt    = '0;
                            n_state  = vsbp_pkg::ST_FLUSH;
                        end
                        vsbp_pkg::ACT_NONE: begin
                        end
                    endcase
                end
            end

            vsbp_pkg::ST_RUN: begin
                // a new byte can only move on once the held one has a place
                if (!(full && r_hold_v && !out_free)) begin
                    if (full) begin
                        if (r_hold_v) begin
                            n_ob    = r_hold;
                            n_olast = 1'b0;
                            n_ov    = 1'b1;
                        end
                        n_hold   = acc[vsbp_pkg::BYTE_W-1:0];
                        n_hold_v = 1'b1;
                        n_bits   = {3'b000, acc[vsbp_pkg::ACC_W-1:vsbp_pkg::BYTE_W]};
                    end else begin
                        n_bits = acc[vsbp_pkg::BITS_W-1:0];
                    end
                    n_cnt = sum[vsbp_pkg::CNT_W-1:0];
                    if (more) begin
                        n_val = r_val >> vsbp_pkg::DATA_W;
                    end else begin
                        n_state = vsbp_pkg::ST_FLUSH;
                    end
                end
            end

            vsbp_pkg::ST_FLUSH: begin
                // final byte of the transaction carries last
                if (!r_hold_v) begin
                    n_state = vsbp_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_ob     = r_hold;
                    n_olast  = 1'b1;
                    n_ov     = 1'b1;
                    n_hold_v = 1'b0;
                    n_state  = vsbp_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = vsbp_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vsbp_pkg::ST_IDLE;
            r_bits   <= '0;
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bits   <= n_bits;
            r_cnt    <= n_cnt;
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_ext   <= n_ext;
        r_hold  <= n_hold;
        r_ob    <= n_ob;
        r_olast <= n_olast;
    end

endmodule

/* bench/varint_six_bit_packer_tb.sv */
`timescale 1ns / 1ps

module varint_six_bit_packer_tb;

    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned LONG_HOLD     = 200;
    localparam int unsigned HOLD_AFTER    = 40;
    localparam int unsigned SETTLE_CYCLES = 30;
    localparam int unsigned ITEMS_PER_RUN = 66;

    typedef struct {
        vsbp_pkg::t_action                act;
        logic [vsbp_pkg::VALUE_W-1:0]     val;
    } t_pack_cmd;

    typedef struct {
        logic [vsbp_pkg::BYTE_W-1:0]      data;
        logic                             last;
    } t_packed_byte;

    logic clk;
    logic rst_n;

    vsbp_in_if  in_if ();
    vsbp_out_if out_if ();

    varint_six_bit_packer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // commands waiting to be offered, bytes waiting to come out
    t_pack_cmd    cmd_q[$];
    t_packed_byte byte_q[$];
    t_packed_byte step_bytes[$];

    // packer state as predicted
    logic [vsbp_pkg::BITS_W-1:0] pend_bits;
    logic [vsbp_pkg::CNT_W-1:0]  pend_cnt;

    int unsigned  tx_idle_pct;
    int unsigned  rx_idle_pct;
    int unsigned  sent_count;
    int unsigned  hold_left;
    bit           long_hold_done;
    int unsigned  mismatch_count;
    int unsigned  stall_cycles;
    t_pack_cmd    next_cmd;
    t_packed_byte want;

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // adds one 6-bit group and emits every complete byte
    task automatic append_group(input logic [vsbp_pkg::GROUP_W-1:0] grp);
        logic [vsbp_pkg::ACC_W-1:0] acc;
        logic [3:0]                 cnt;
        acc = {5'b0, pend_bits} | ({6'b0, grp} << pend_cnt);
        cnt = {1'b0, pend_cnt} + 4'd6;
        while (cnt >= 4'd8) begin
            step_bytes.insert(step_bytes.size(),
                              '{data: acc[vsbp_pkg::BYTE_W-1:0], last: 1'b0});
            acc = acc >> 8;
            cnt = cnt - 4'd8;
        end
        pend_bits = acc[vsbp_pkg::BITS_W-1:0];
        pend_cnt  = cnt[vsbp_pkg::CNT_W-1:0];
    endtask

    // works out the bytes one accepted command produces
    task automatic pack_command(input vsbp_pkg::t_action act,
                                input logic [vsbp_pkg::VALUE_W-1:0] val);
        logic [vsbp_pkg::VALUE_W-1:0] rest;
        step_bytes.delete();
        case (act)
            vsbp_pkg::ACT_FIXED: begin
                append_group(val[vsbp_pkg::GROUP_W-1:0]);
            end
            vsbp_pkg::ACT_EXT: begin
                rest = val;
                while (rest >= 32'd32) begin
                    append_group({1'b1, rest[vsbp_pkg::DATA_W-1:0]});
                    rest = rest >> vsbp_pkg::DATA_W;
                end
                append_group({1'b0, rest[vsbp_pkg::DATA_W-1:0]});
            end
            vsbp_pkg::ACT_FINISH: begin
                if (pend_cnt != '0) begin
                    step_bytes.insert(step_bytes.size(),
                                      '{data: {1'b0, pend_bits}, last: 1'b0});
                end
                pend_bits = '0;
                pend_cnt  = '0;
            end
            default: begin
            end
        endcase
        if (step_bytes.size() != 0) begin
            step_bytes[step_bytes.size()-1].last = 1'b1;
        end
        foreach (step_bytes[k]) byte_q.insert(byte_q.size(), step_bytes[k]);
    endtask

    function automatic t_pack_cmd random_cmd();
        t_pack_cmd c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            c.act = vsbp_pkg::ACT_FIXED;
            c.val = $urandom;
        end else if (pick < 82) begin
            c.act = vsbp_pkg::ACT_EXT;
            c.val = $urandom >> $urandom_range(0, 31);
        end else if (pick < 96) begin
            c.act = vsbp_pkg::ACT_FINISH;
            c.val = $urandom;
        end else begin
            c.act = vsbp_pkg::ACT_NONE;
            c.val = $urandom;
        end
        return c;
    endfunction

    // transaction driver on the input channel
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid  <= 1'b0;
            in_if.action <= vsbp_pkg::ACT_NONE;
            in_if.value  <= '0;
            pend_bits    = '0;
            pend_cnt     = '0;
            sent_count   <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                pack_command(vsbp_pkg::t_action'(in_if.action), in_if.value);
                sent_count <= sent_count + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    next_cmd = cmd_q.pop_front();
                    in_if.valid  <= 1'b1;
                    in_if.action <= next_cmd.act;
                    in_if.value  <= next_cmd.val;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // output ready, with one long hold-off while the sender keeps offering
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready   <= 1'b0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end else if (!long_hold_done && sent_count >= HOLD_AFTER) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            out_if.ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // output transaction check against the oldest predicted byte
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (byte_q.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual byte %02h last %b",
                         $time, out_if.out_byte, out_if.last);
                mismatch_count++;
            end else begin
                want = byte_q.pop_front();
                if (out_if.out_byte !== want.data) begin
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.data, out_if.out_byte);
                    mismatch_count++;
                end
                if (out_if.last !== want.last) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, out_if.last);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("varint_six_bit_packer_tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_cmd(input vsbp_pkg::t_action act,
                           input logic [vsbp_pkg::VALUE_W-1:0] val);
        cmd_q.insert(cmd_q.size(), '{act: act, val: val});
    endtask

    // waits until every command is taken and every byte has come out
    task automatic wait_drained();
        @(negedge clk);
        while (cmd_q.size() != 0 || in_if.valid || byte_q.size() != 0) @(negedge clk);
    endtask

    task automatic add_random_run();
        int unsigned counted;
        t_pack_cmd c;
        counted = 0;
        while (counted < ITEMS_PER_RUN) begin
            c = random_cmd();
            cmd_q.insert(cmd_q.size(), c);
            if (c.act != vsbp_pkg::ACT_NONE) counted++;
        end
    endtask

    // stimulus sequence
    initial begin
        rst_n          = 1'b0;
        tx_idle_pct    = 14;
        rx_idle_pct    = 55;

        // directed: empty finish, field extremes, group boundaries, ignored code
        add_cmd(vsbp_pkg::ACT_FINISH, 32'h0000_0000);
        add_cmd(vsbp_pkg::ACT_FIXED,  32'h0000_0000);
        add_cmd(vsbp_pkg::ACT_FIXED,  32'h0000_003F);
        add_cmd(vsbp_pkg::ACT_FIXED,  32'hFFFF_FFC0);
        add_cmd(vsbp_pkg::ACT_FIXED,  32'hFFFF_FFFF);
        add_cmd(vsbp_pkg::ACT_FIXED,  32'h0000_002A);
        add_cmd(vsbp_pkg::ACT_FINISH, 32'hFFFF_FFFF);
        add_cmd(vsbp_pkg::ACT_EXT,    32'h0000_0000);
        add_cmd(vsbp_pkg::ACT_EXT,    32'h0000_001F);
        add_cmd(vsbp_pkg::ACT_EXT,    32'h0000_0020);
        add_cmd(vsbp_pkg::ACT_FINISH, 32'h0000_0000);
        add_cmd(vsbp_pkg::ACT_EXT,    32'hFFFF_FFFF);
        add_cmd(vsbp_pkg::ACT_EXT,    32'h8000_0000);
        add_cmd(vsbp_pkg::ACT_EXT,    32'hAAAA_AAAA);
        add_cmd(vsbp_pkg::ACT_NONE,   32'hFFFF_FFFF);
        add_cmd(vsbp_pkg::ACT_FIXED,  32'h0000_0015);
        add_cmd(vsbp_pkg::ACT_NONE,   32'h0000_0000);
        add_cmd(vsbp_pkg::ACT_FINISH, 32'h0000_0000);
        add_cmd(vsbp_pkg::ACT_FINISH, 32'h0000_0000);
        // six held bits followed by the longest varint
        add_cmd(vsbp_pkg::ACT_FIXED,  32'h0000_003F);
        add_cmd(vsbp_pkg::ACT_EXT,    32'hFFFF_FFFF);
        add_cmd(vsbp_pkg::ACT_FINISH, 32'h0000_0000);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        add_random_run();
        wait_drained();

        // sender idles more than the receiver
        tx_idle_pct <= 55;
        rx_idle_pct <= 14;
        add_random_run();
        wait_drained();

        // no idling on either side
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        add_random_run();
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && byte_q.size() == 0) begin
            $display("varint_six_bit_packer_tb passed");
        end else begin
            $display("varint_six_bit_packer_tb failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/vsbp_pkg.sv
rtl/vsbp_in_if.sv
rtl/vsbp_out_if.sv
rtl/varint_six_bit_packer.sv
bench/varint_six_bit_packer_tb.sv
